[hw/rtl/sota_pkg.sv]
// Shared types, constants and handle helpers for the open table admission block.
`default_nettype none
package sota_pkg;

   localparam int SLOTS = 8;
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int KEY_W = 32;
   localparam int HANDLE_W = 8;
   localparam logic [31:0] HANDLE_STEP = 32'd10;

   typedef enum logic [0:0] {
      OP_OPEN  = 1'b0,
      OP_CLOSE = 1'b1
   } opcode_type;

   typedef enum logic [2:0] {
      ST_OK             = 3'd0,
      ST_NOT_ACCESSIBLE = 3'd1,
      ST_REFUSED        = 3'd2,
      ST_INVALID_MODE   = 3'd3,
      ST_FULL           = 3'd4,
      ST_BAD_HANDLE     = 3'd5
   } status_type;

   // connection modes
   localparam logic [1:0] MODE_UNRESTRICTED = 2'd0;
   localparam logic [1:0] MODE_EXCLUSIVE    = 2'd1;
   localparam logic [1:0] MODE_TRANSACTION  = 2'd2;
   localparam logic [1:0] MODE_INVALID      = 2'd3;

   // open flags; 3 is stored as given
   localparam logic [1:0] FLAG_RDONLY = 2'd0;
   localparam logic [1:0] FLAG_WRONLY = 2'd1;
   localparam logic [1:0] FLAG_RDWR   = 2'd2;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FIN
   } state_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [1:0]       mode;
      logic [1:0]       flags;
   } entry_type;

   typedef struct packed {
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      entry_type        wr_data;
   } mem_req_type;

   typedef struct packed {
      status_type           status;
      logic [HANDLE_W-1:0]  handle;
   } result_type;

   // -10*(slot+1) as a 32-bit pattern
   function automatic logic [31:0] slot_handle(input logic [IDX_W-1:0] idx);
      logic [31:0] n;
      n = 32'(idx) + 32'd1;
      return 32'd0 - (n * HANDLE_STEP);
   endfunction

   function automatic logic [HANDLE_W-1:0] slot_handle_field(input logic [IDX_W-1:0] idx);
      logic [31:0] h;
      h = slot_handle(idx);
      return h[HANDLE_W-1:0];
   endfunction

endpackage
`default_nettype wire

[hw/rtl/shared_open_table_admission_top.sv]
// Top level of the shared open table admission block: ports, table store and result register.
`default_nettype none
// Open-file table with sharing-mode admission. Each request beat is one open or
// close; each gives exactly one response beat (status, handle). The entries sit
// in a single-port-read synchronous RAM with a valid bit per slot in flops, so
// reset empties the table at once. An open or close walks the RAM one slot per
// cycle, set by the one read per cycle on the entry RAM; the block takes no new
// request until it is back in idle. After the reads come the compare of the last
// slot, the wind-down of the walk, a completion state and the idle state in which
// the next request is taken. An open refused as not accessible or as invalid mode
// skips the walk and goes straight to completion. The response sits in an output
// register; a new request is taken while it waits, and the block only holds its
// completion until that register frees up.
// Handles are -10*(slot+1) in 8 bits; close of any handle that names no valid
// slot (including 0) returns bad handle and changes nothing.
module shared_open_table_admission_top
   import sota_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   // request channel
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic             req_opcode,
   input  wire logic [KEY_W-1:0] req_path_key,
   input  wire logic [1:0]       req_conn_mode,
   input  wire logic [1:0]       req_open_flags,
   input  wire logic             req_file_accessible,
   input  wire logic signed [31:0] req_close_handle,
   // response channel
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [2:0]            rsp_status,
   output logic signed [HANDLE_W-1:0] rsp_handle
);

   mem_req_type mem_req;
   entry_type   rd_data;
   result_type  result;
   logic        push;
   logic        busy;
   logic        out_free;

   logic                rsp_valid_ff;
   logic [2:0]          rsp_status_ff;
   logic [HANDLE_W-1:0] rsp_handle_ff;

   // output register can take a new beat when empty or draining this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   sota_ctrl u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_opcode          (req_opcode),
      .req_path_key        (req_path_key),
      .req_conn_mode       (req_conn_mode),
      .req_open_flags      (req_open_flags),
      .req_file_accessible (req_file_accessible),
      .req_close_handle    (req_close_handle),
      .req_busy            (busy),
      .out_free            (out_free),
      .push                (push),
      .result              (result),
      .mem_req             (mem_req),
      .rd_data             (rd_data)
   );

   sota_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (push) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_status_ff <= result.status;
         rsp_handle_ff <= result.handle;
      end
   end

   assign req_stall  = busy;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_handle = rsp_handle_ff;

endmodule
`default_nettype wire

[hw/rtl/sota_ram.sv]
// Entry store: key, mode and flags per slot, one write and one registered read port.
`default_nettype none
module sota_ram
   import sota_pkg::*;
(
   input  wire logic        clock,
   input  wire mem_req_type mem_req,
   output entry_type        rd_data
);

   entry_type mem [SLOTS];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[hw/rtl/sota_ctrl.sv]
// Scan sequencer: valid bits, policy/reuse/free search and table update.
`default_nettype none
module sota_ctrl
   import sota_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_opcode,
   input  wire logic [KEY_W-1:0] req_path_key,
   input  wire logic [1:0]       req_conn_mode,
   input  wire logic [1:0]       req_open_flags,
   input  wire logic             req_file_accessible,
   input  wire logic [31:0]      req_close_handle,
   output logic                  req_busy,
   input  wire logic             out_free,
   output logic                  push,
   output result_type            result,
   output mem_req_type           mem_req,
   input  wire entry_type        rd_data
);

   state_type state_ff, state_in;

   // latched request
   opcode_type       op_ff;
   logic [KEY_W-1:0] key_ff;
   logic [1:0]       mode_ff;
   logic [1:0]       flags_ff;
   logic             acc_ff;
   logic [31:0]      hreq_ff;

   logic [SLOTS-1:0] valid_ff;
   logic [CNT_W-1:0] rd_cnt_ff;
   logic             cmp_vld_ff;
   logic [IDX_W-1:0] cmp_idx_ff;
   logic             refuse_ff;
   logic             hit_ff;
   logic [IDX_W-1:0] hit_idx_ff;
   logic             free_ff;
   logic [IDX_W-1:0] free_idx_ff;

   logic take;
   logic ent_valid;
   logic key_eq;
   logic set_valid;
   logic clr_valid;

   assign take      = req_valid && (state_ff == S_IDLE);
   assign req_busy  = (state_ff != S_IDLE);
   assign ent_valid = valid_ff[cmp_idx_ff];
   assign key_eq    = (rd_data.key == key_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (take) begin
               if (opcode_type'(req_opcode) == OP_OPEN &&
                   (!req_file_accessible || req_conn_mode == MODE_INVALID)) begin
                  state_in = S_FIN;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (rd_cnt_ff == CNT_W'(SLOTS) && !cmp_vld_ff) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      mem_req         = '0;
      mem_req.rd_en   = (state_ff == S_SCAN) && (rd_cnt_ff < CNT_W'(SLOTS));
      mem_req.rd_addr = rd_cnt_ff[IDX_W-1:0];
      push            = (state_ff == S_FIN) && out_free;
      set_valid       = 1'b0;
      clr_valid       = 1'b0;
      result.status   = ST_OK;
      result.handle   = '0;
      if (op_ff == OP_CLOSE) begin
         if (hit_ff) begin
            result.handle   = hreq_ff[HANDLE_W-1:0];
            mem_req.wr_addr = hit_idx_ff;
            clr_valid       = 1'b1;
         end else begin
            result.status = ST_BAD_HANDLE;
         end
      end else if (!acc_ff) begin
         result.status = ST_NOT_ACCESSIBLE;
      end else if (mode_ff == MODE_INVALID) begin
         result.status = ST_INVALID_MODE;
      end else if (refuse_ff) begin
         result.status = ST_REFUSED;
      end else if (hit_ff) begin
         result.handle = slot_handle_field(hit_idx_ff);
      end else if (free_ff) begin
         result.handle         = slot_handle_field(free_idx_ff);
         mem_req.wr_addr       = free_idx_ff;
         mem_req.wr_data.key   = key_ff;
         mem_req.wr_data.mode  = mode_ff;
         mem_req.wr_data.flags = flags_ff;
         set_valid             = 1'b1;
      end else begin
         result.status = ST_FULL;
      end
      mem_req.wr_en = push && (set_valid || clr_valid);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         valid_ff   <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cmp_vld_ff <= mem_req.rd_en;
         if (push && set_valid) begin
            valid_ff[mem_req.wr_addr] <= 1'b1;
         end
         if (push && clr_valid) begin
            valid_ff[mem_req.wr_addr] <= 1'b0;
         end
      end
   end

   // request latch and scan bookkeeping
   always_ff @(posedge clock) begin
      if (take) begin
         op_ff       <= opcode_type'(req_opcode);
         key_ff      <= req_path_key;
         mode_ff     <= req_conn_mode;
         flags_ff    <= req_open_flags;
         acc_ff      <= req_file_accessible;
         hreq_ff     <= req_close_handle;
         rd_cnt_ff   <= '0;
         refuse_ff   <= 1'b0;
         hit_ff      <= 1'b0;
         free_ff     <= 1'b0;
         hit_idx_ff  <= '0;
         free_idx_ff <= '0;
      end else begin
         if (mem_req.rd_en) begin
            rd_cnt_ff <= rd_cnt_ff + CNT_W'(1);
         end
         if (cmp_vld_ff) begin
            if (op_ff == OP_CLOSE) begin
               if (ent_valid && !hit_ff && slot_handle(cmp_idx_ff) == hreq_ff) begin
                  hit_ff     <= 1'b1;
                  hit_idx_ff <= cmp_idx_ff;
               end
            end else begin
               if (ent_valid && key_eq) begin
                  if (mode_ff == MODE_TRANSACTION) begin
                     refuse_ff <= 1'b1;
                  end
                  if (mode_ff == MODE_EXCLUSIVE &&
                      (rd_data.flags == FLAG_WRONLY || rd_data.flags == FLAG_RDWR)) begin
                     refuse_ff <= 1'b1;
                  end
               end
               if (ent_valid && key_eq && !hit_ff && rd_data.mode == mode_ff &&
                   rd_data.flags == flags_ff) begin
                  hit_ff     <= 1'b1;
                  hit_idx_ff <= cmp_idx_ff;
               end
               if (!ent_valid && !free_ff) begin
                  free_ff     <= 1'b1;
                  free_idx_ff <= cmp_idx_ff;
               end
            end
         end
      end
      cmp_idx_ff <= mem_req.rd_addr;
   end

`ifndef SYNTHESIS
   a_rd_in_range: assert property (@(posedge clock) disable iff (reset)
      mem_req.rd_en |-> (rd_cnt_ff < CNT_W'(SLOTS)))
      else $error("table read beyond last slot");

   a_fail_zero_handle: assert property (@(posedge clock) disable iff (reset)
      (push && result.status != ST_OK) |-> (result.handle == '0))
      else $error("refused beat carries a handle");

   a_write_on_push: assert property (@(posedge clock) disable iff (reset)
      mem_req.wr_en |-> (push && state_ff == S_FIN))
      else $error("table written outside completion");

   a_close_frees: assert property (@(posedge clock) disable iff (reset)
      (push && op_ff == OP_CLOSE && hit_ff) |=> !valid_ff[$past(hit_idx_ff)])
      else $error("closed slot still valid");

   a_grant_fills: assert property (@(posedge clock) disable iff (reset)
      (push && set_valid) |=> valid_ff[$past(free_idx_ff)])
      else $error("allocated slot not marked valid");
`endif

endmodule
`default_nettype wire

[tb/tb_shared_open_table_admission_top.sv]
// Self-checking testbench for the shared open table admission block.
module tb_shared_open_table_admission_top;
   timeunit 1ns;
   timeprecision 1ps;
   import sota_pkg::*;

   // Stimulus sizes and time limits.
   localparam int N_RANDOM       = 1625;
   localparam int N_DIRECTED     = 25;
   localparam int HOLD_CYCLES    = 300;         // long receiver hold-off
   localparam int WATCHDOG_LIMIT = 5000;        // cycles with no beat on either side
   localparam int DRAIN_CYCLES   = 4 * (SLOTS + 4);
   localparam int HOLD_AT        = 200;         // random beat that triggers the hold-off
   localparam int PAUSE_AT       = 700;         // random beat that waits for a drained table
   localparam logic [1:0] FLAG_UNDEFINED = 2'd3; // stored and compared as given

   typedef struct {
      opcode_type         op;
      logic [KEY_W-1:0]   key;
      logic [1:0]         mode;
      logic [1:0]         flags;
      logic               acc;
      logic signed [31:0] hnd;
   } request_type;

   typedef struct {
      status_type                 status;
      logic signed [HANDLE_W-1:0] handle;
   } reply_type;

   typedef struct {
      request_type rq;
      logic        typed;   // expected reply typed in the row instead of predicted
      reply_type   rp;
   } dir_row_type;

   localparam reply_type UNTYPED = '{ST_OK, 8'sd0};

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_valid           = 1'b0;
   logic                       req_stall;
   logic                       req_opcode          = 1'b0;
   logic [KEY_W-1:0]           req_path_key        = '0;
   logic [1:0]                 req_conn_mode       = '0;
   logic [1:0]                 req_open_flags      = '0;
   logic                       req_file_accessible = 1'b0;
   logic signed [31:0]         req_close_handle    = '0;
   logic                       rsp_valid;
   logic                       rsp_stall           = 1'b0;
   logic [2:0]                 rsp_status;
   logic signed [HANDLE_W-1:0] rsp_handle;

   shared_open_table_admission_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_opcode          (req_opcode),
      .req_path_key        (req_path_key),
      .req_conn_mode       (req_conn_mode),
      .req_open_flags      (req_open_flags),
      .req_file_accessible (req_file_accessible),
      .req_close_handle    (req_close_handle),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_handle          (rsp_handle)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Shadow of the open table. Updated once per accepted request beat,
   // in acceptance order, so it always matches what the block holds.
   // ------------------------------------------------------------------
   logic             tbl_valid [SLOTS];
   logic [KEY_W-1:0] tbl_key   [SLOTS];
   logic [1:0]       tbl_mode  [SLOTS];
   logic [1:0]       tbl_flags [SLOTS];

   reply_type pending_replies [$];   // replies owed by the block, oldest first
   int        errors = 0;

   // Slot i owns handle -10*(i+1), as a 32-bit pattern.
   function automatic logic [31:0] handle_of(int i);
      return 32'(-10 * (i + 1));
   endfunction

   function automatic reply_type admit_or_release(request_type rq);
      reply_type   r;
      logic        admit;
      logic [31:0] h;
      r.status = ST_OK;
      r.handle = '0;
      if (rq.op == OP_CLOSE) begin
         // only a valid slot can be released, so 0 and positives never match
         for (int i = 0; i < SLOTS; i++) begin
            if (tbl_valid[i] && handle_of(i) == rq.hnd) begin
               tbl_valid[i] = 1'b0;
               tbl_key[i]   = '0;
               tbl_mode[i]  = '0;
               tbl_flags[i] = '0;
               r.handle = rq.hnd[HANDLE_W-1:0];
               return r;
            end
         end
         r.status = ST_BAD_HANDLE;
         return r;
      end
      // check order: accessibility, mode, sharing policy, reuse, allocation
      if (!rq.acc) begin
         r.status = ST_NOT_ACCESSIBLE;
         return r;
      end
      if (rq.mode == MODE_INVALID) begin
         r.status = ST_INVALID_MODE;
         return r;
      end
      admit = 1'b1;
      for (int i = 0; i < SLOTS; i++) begin
         if (tbl_valid[i] && tbl_key[i] == rq.key) begin
            if (rq.mode == MODE_TRANSACTION)
               admit = 1'b0;
            // undefined flags never count as write access
            if (rq.mode == MODE_EXCLUSIVE &&
                (tbl_flags[i] == FLAG_WRONLY || tbl_flags[i] == FLAG_RDWR))
               admit = 1'b0;
         end
      end
      if (!admit) begin
         r.status = ST_REFUSED;
         return r;
      end
      for (int i = 0; i < SLOTS; i++) begin
         if (tbl_valid[i] && tbl_key[i] == rq.key && tbl_mode[i] == rq.mode &&
             tbl_flags[i] == rq.flags) begin
            h = handle_of(i);
            r.handle = h[HANDLE_W-1:0];
            return r;
         end
      end
      for (int i = 0; i < SLOTS; i++) begin
         if (!tbl_valid[i]) begin
            tbl_valid[i] = 1'b1;
            tbl_key[i]   = rq.key;
            tbl_mode[i]  = rq.mode;
            tbl_flags[i] = rq.flags;
            h = handle_of(i);
            r.handle = h[HANDLE_W-1:0];
            return r;
         end
      end
      r.status = ST_FULL;
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      errors++;
   endtask

   // ------------------------------------------------------------------
   // Request side. Fields ride with a tb-only expected reply for the
   // directed rows that carry one.
   // ------------------------------------------------------------------
   logic      dir_typed = 1'b0;
   reply_type dir_reply;

   int send_idle_pct  = 8;    // sender gap chance per beat, in percent
   int recv_stall_pct = 51;   // receiver stall chance per cycle, in percent
   int hold_asks      = 0;    // bumped by the driver to request a long hold-off

   logic [KEY_W-1:0] hot_keys [4];   // small pool so paths collide often

   function automatic request_type open_req(logic [KEY_W-1:0] key, logic [1:0] mode,
                                            logic [1:0] flags, logic acc);
      request_type rq;
      rq.op    = OP_OPEN;
      rq.key   = key;
      rq.mode  = mode;
      rq.flags = flags;
      rq.acc   = acc;
      rq.hnd   = $urandom;   // ignored on open
      return rq;
   endfunction

   function automatic request_type close_req(logic signed [31:0] hnd);
      request_type rq;
      rq.op    = OP_CLOSE;
      rq.key   = $urandom;   // open-only fields are noise here
      rq.mode  = 2'($urandom);
      rq.flags = 2'($urandom);
      rq.acc   = 1'($urandom);
      rq.hnd   = hnd;
      return rq;
   endfunction

   function automatic request_type random_request();
      request_type rq;
      int          pick;
      rq.op  = ($urandom_range(99) < 40) ? OP_CLOSE : OP_OPEN;
      rq.key = ($urandom_range(9) == 0) ? $urandom : hot_keys[$urandom_range(3)];
      pick = $urandom_range(99);
      rq.mode = (pick < 8)  ? MODE_INVALID :
                (pick < 40) ? MODE_UNRESTRICTED :
                (pick < 70) ? MODE_EXCLUSIVE : MODE_TRANSACTION;
      pick = $urandom_range(99);
      rq.flags = (pick < 6)  ? FLAG_UNDEFINED :
                 (pick < 40) ? FLAG_RDONLY :
                 (pick < 70) ? FLAG_WRONLY : FLAG_RDWR;
      rq.acc = ($urandom_range(99) >= 8);
      // mostly live slot handles, some zero, some wide random values
      pick = $urandom_range(99);
      if (pick < 75)
         rq.hnd = -32'sd10 * $signed(32'($urandom_range(1, SLOTS)));
      else if (pick < 85)
         rq.hnd = 32'sd0;
      else
         rq.hnd = $urandom;
      return rq;
   endfunction

   // Optional gap, then hold the beat until the block takes it.
   task automatic offer(request_type rq, logic typed, reply_type rp);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_opcode          <= rq.op;
      req_path_key        <= rq.key;
      req_conn_mode       <= rq.mode;
      req_open_flags      <= rq.flags;
      req_file_accessible <= rq.acc;
      req_close_handle    <= rq.hnd;
      dir_typed           <= typed;
      dir_reply           <= rp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_for_drain();
      do @(posedge clock); while (pending_replies.size() != 0);
   endtask

   // ------------------------------------------------------------------
   // Receiver: random stalls, plus a long hold-off on request. The hold-off
   // is counted here so the sender keeps pushing and the block backs up.
   // ------------------------------------------------------------------
   int hold_left   = 0;
   int hold_served = 0;

   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_asks != hold_served) begin
         rsp_stall   <= 1'b1;
         hold_served <= hold_asks;
         hold_left   <= HOLD_CYCLES - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // ------------------------------------------------------------------
   // Scoreboard: predict on each request beat, compare on each reply beat.
   // Both sample the values present at the edge.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : scoreboard
      request_type seen;
      reply_type   want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            seen.op    = opcode_type'(req_opcode);
            seen.key   = req_path_key;
            seen.mode  = req_conn_mode;
            seen.flags = req_open_flags;
            seen.acc   = req_file_accessible;
            seen.hnd   = req_close_handle;
            want = admit_or_release(seen);   // always run to keep the table in step
            if (dir_typed)
               want = dir_reply;
            pending_replies.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_replies.size() == 0) begin
               report_mismatch("unexpected reply status", int'(rsp_status), -1);
            end else begin
               want = pending_replies.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", int'(rsp_status), int'(want.status));
               if (rsp_handle !== want.handle)
                  report_mismatch("handle", int'(rsp_handle), int'(want.handle));
            end
         end
      end
   end

   // Watchdog: any beat on either side resets the count.
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[%0t] no beat for %0d cycles", $realtime, WATCHDOG_LIMIT);
         $display("** shared_open_table_admission_top: FAILED **");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   dir_row_type dir_rows [N_DIRECTED];

   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         tbl_valid[i] = 1'b0;
         tbl_key[i]   = '0;
         tbl_mode[i]  = '0;
         tbl_flags[i] = '0;
      end
      for (int i = 0; i < 4; i++)
         hot_keys[i] = $urandom;

      // empty table: every close is a bad handle, including extremes
      dir_rows[0]  = '{close_req(32'sd0), 1'b1, '{ST_BAD_HANDLE, 8'sd0}};
      dir_rows[1]  = '{close_req(-32'sd10), 1'b1, '{ST_BAD_HANDLE, 8'sd0}};
      dir_rows[2]  = '{close_req(32'sh7FFF_FFFF), 1'b1, '{ST_BAD_HANDLE, 8'sd0}};
      dir_rows[3]  = '{close_req(32'sh8000_0000), 1'b1, '{ST_BAD_HANDLE, 8'sd0}};
      // accessibility wins over an invalid mode; then the invalid mode itself
      dir_rows[4]  = '{open_req(32'hFFFF_FFFF, MODE_INVALID, FLAG_UNDEFINED, 1'b0), 1'b1,
                       '{ST_NOT_ACCESSIBLE, 8'sd0}};
      dir_rows[5]  = '{open_req(32'h0, MODE_INVALID, FLAG_RDONLY, 1'b1), 1'b1,
                       '{ST_INVALID_MODE, 8'sd0}};
      // first grant lands in slot 0, then an identical open reuses it
      dir_rows[6]  = '{open_req(32'h0, MODE_UNRESTRICTED, FLAG_RDONLY, 1'b1), 1'b1,
                       '{ST_OK, -8'sd10}};
      dir_rows[7]  = '{open_req(32'h0, MODE_UNRESTRICTED, FLAG_RDONLY, 1'b1), 1'b0, UNTYPED};
      // exclusive next to a reader passes; exclusive next to a writer is refused
      dir_rows[8]  = '{open_req(32'h0, MODE_EXCLUSIVE, FLAG_RDWR, 1'b1), 1'b0, UNTYPED};
      dir_rows[9]  = '{open_req(32'h0, MODE_EXCLUSIVE, FLAG_RDONLY, 1'b1), 1'b0, UNTYPED};
      // transaction refused on any holder of the path, granted on a path with none
      dir_rows[10] = '{open_req(32'h0, MODE_TRANSACTION, FLAG_RDONLY, 1'b1), 1'b0, UNTYPED};
      dir_rows[11] = '{open_req(32'hFFFF_FFFF, MODE_TRANSACTION, FLAG_WRONLY, 1'b1), 1'b0,
                       UNTYPED};
      dir_rows[12] = '{open_req(32'hFFFF_FFFF, MODE_UNRESTRICTED, FLAG_UNDEFINED, 1'b1), 1'b0,
                       UNTYPED};
      // undefined flags do not block an exclusive open
      dir_rows[13] = '{open_req(32'hA5A5_5A5A, MODE_UNRESTRICTED, FLAG_UNDEFINED, 1'b1), 1'b0,
                       UNTYPED};
      dir_rows[14] = '{open_req(32'hA5A5_5A5A, MODE_EXCLUSIVE, FLAG_WRONLY, 1'b1), 1'b0,
                       UNTYPED};
      // fill the last two slots, then overflow
      dir_rows[15] = '{open_req(32'h0000_0001, MODE_UNRESTRICTED, FLAG_RDONLY, 1'b1), 1'b0,
                       UNTYPED};
      dir_rows[16] = '{open_req(32'h8000_0000, MODE_UNRESTRICTED, FLAG_RDONLY, 1'b1), 1'b1,
                       '{ST_OK, -8'sd80}};
      dir_rows[17] = '{open_req(32'h0000_0002, MODE_UNRESTRICTED, FLAG_RDONLY, 1'b1), 1'b1,
                       '{ST_FULL, 8'sd0}};
      // reuse still works on a full table
      dir_rows[18] = '{open_req(32'h0, MODE_UNRESTRICTED, FLAG_RDONLY, 1'b1), 1'b0, UNTYPED};
      // release the last slot, twice, then slot 1
      dir_rows[19] = '{close_req(-32'sd80), 1'b1, '{ST_OK, -8'sd80}};
      dir_rows[20] = '{close_req(-32'sd80), 1'b1, '{ST_BAD_HANDLE, 8'sd0}};
      dir_rows[21] = '{close_req(-32'sd20), 1'b0, UNTYPED};
      // freed slot 1 is the first free one again
      dir_rows[22] = '{open_req(32'h0000_0002, MODE_UNRESTRICTED, FLAG_RDONLY, 1'b1), 1'b0,
                       UNTYPED};
      // positive and off-grid handles never match
      dir_rows[23] = '{close_req(32'sd80), 1'b1, '{ST_BAD_HANDLE, 8'sd0}};
      dir_rows[24] = '{close_req(-32'sd85), 1'b1, '{ST_BAD_HANDLE, 8'sd0}};

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_DIRECTED; i++)
         offer(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].rp);

      // Random part in three idling phases: sender mostly busy with a slow
      // receiver, then the reverse, then both at full rate.
      for (int n = 0; n < N_RANDOM; n++) begin
         if (n == N_RANDOM / 3) begin
            send_idle_pct  = 51;
            recv_stall_pct = 8;
         end else if (n == 2 * N_RANDOM / 3) begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         if (n == HOLD_AT)
            hold_asks <= hold_asks + 1;   // block fills and stalls the request side
         if (n == PAUSE_AT) begin
            req_valid <= 1'b0;
            wait_for_drain();
         end
         offer(random_request(), 1'b0, UNTYPED);
      end

      req_valid <= 1'b0;
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("** shared_open_table_admission_top: PASSED **");
      else
         $display("** shared_open_table_admission_top: FAILED **");
      $finish;
   end

endmodule

[sim.f]
hw/rtl/sota_pkg.sv
hw/rtl/sota_ram.sv
hw/rtl/sota_ctrl.sv
hw/rtl/shared_open_table_admission_top.sv
tb/tb_shared_open_table_admission_top.sv
